### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL files.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked only while out of reset.
`define CRH_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked only while out of reset.
`define CRH_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("assertion failed: next-cycle implication");

`endif

### rtl/core/crh_pkg.sv
package crh_pkg;

	// Coordinate format and the widths derived from it.
	localparam int CRH_COORD_W = 24;
	localparam int CRH_R_W     = CRH_COORD_W - 1;
	localparam int CRH_DIFF_W  = CRH_COORD_W + 1;
	localparam int CRH_PROD_W  = 2 * CRH_DIFF_W;
	localparam int CRH_SUMSQ_W = 2 * CRH_COORD_W + 1;
	localparam int CRH_RT_W    = CRH_COORD_W + 1;
	localparam int CRH_RAD_W   = 2 * CRH_RT_W;
	localparam int CRH_NUM_W   = 2 * CRH_COORD_W + 1;
	localparam int CRH_DW_W    = CRH_COORD_W + 2;

	typedef struct packed {
		logic signed [CRH_COORD_W-1:0] circle_x;
		logic signed [CRH_COORD_W-1:0] circle_y;
		logic        [CRH_R_W-1:0]     radius;
		logic signed [CRH_COORD_W-1:0] centre_x;
		logic signed [CRH_COORD_W-1:0] centre_y;
		logic signed [CRH_COORD_W-1:0] top_mid_x;
		logic signed [CRH_COORD_W-1:0] top_mid_y;
		logic signed [CRH_COORD_W-1:0] right_mid_x;
		logic signed [CRH_COORD_W-1:0] right_mid_y;
	} in_item_t;

	typedef struct packed {
		logic hit;
		logic degenerate;
	} out_item_t;

	// Front end result: radicands, cross magnitudes and radius.
	typedef struct packed {
		logic [CRH_SUMSQ_W-1:0] sq_w;
		logic [CRH_SUMSQ_W-1:0] sq_h;
		logic [CRH_NUM_W-1:0]   cr_w;
		logic [CRH_NUM_W-1:0]   cr_h;
		logic [CRH_R_W-1:0]     r;
	} front_t;

	// Values that ride alongside the square root lanes.
	typedef struct packed {
		logic [CRH_NUM_W-1:0] cr_w;
		logic [CRH_NUM_W-1:0] cr_h;
		logic [CRH_R_W-1:0]   r;
	} sqrt_sb_t;

endpackage

### rtl/core/crh_front.sv
module crh_front import crh_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      in_valid,
	input  in_item_t  in_item,
	output logic      out_valid,
	output front_t    out_front
);

	logic v_s1, v_s2, v_s3;

	logic signed [CRH_DIFF_W-1:0] cx_s1, cy_s1, tx_s1, ty_s1, rx_s1, ry_s1;
	logic [CRH_R_W-1:0] r_s1, r_s2;

	logic signed [CRH_PROD_W-1:0] rxrx_s2, ryry_s2, txtx_s2, tyty_s2;
	logic signed [CRH_PROD_W-1:0] txcy_s2, tycx_s2, rxcy_s2, rycx_s2;

	logic signed [CRH_PROD_W:0] crw_raw, crh_raw;
	logic [CRH_PROD_W:0] crw_abs, crh_abs;
	logic [CRH_PROD_W-1:0] sqw_sum, sqh_sum;

	front_t front_s3;

	// Valid bits move with the data whenever the pipeline advances.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage 1: offsets from the rectangle centre.
	always_ff @(posedge clk) begin
		if (en) begin
			cx_s1 <= CRH_DIFF_W'(in_item.circle_x) - CRH_DIFF_W'(in_item.centre_x);
			cy_s1 <= CRH_DIFF_W'(in_item.circle_y) - CRH_DIFF_W'(in_item.centre_y);
			tx_s1 <= CRH_DIFF_W'(in_item.top_mid_x) - CRH_DIFF_W'(in_item.centre_x);
			ty_s1 <= CRH_DIFF_W'(in_item.top_mid_y) - CRH_DIFF_W'(in_item.centre_y);
			rx_s1 <= CRH_DIFF_W'(in_item.right_mid_x) - CRH_DIFF_W'(in_item.centre_x);
			ry_s1 <= CRH_DIFF_W'(in_item.right_mid_y) - CRH_DIFF_W'(in_item.centre_y);
			r_s1  <= in_item.radius;
		end
	end

	// Stage 2: one multiplier per product.
	always_ff @(posedge clk) begin
		if (en) begin
			rxrx_s2 <= rx_s1 * rx_s1;
			ryry_s2 <= ry_s1 * ry_s1;
			txtx_s2 <= tx_s1 * tx_s1;
			tyty_s2 <= ty_s1 * ty_s1;
			txcy_s2 <= tx_s1 * cy_s1;
			tycx_s2 <= ty_s1 * cx_s1;
			rxcy_s2 <= rx_s1 * cy_s1;
			rycx_s2 <= ry_s1 * cx_s1;
			r_s2    <= r_s1;
		end
	end

	// Sums of squares and magnitudes of the cross products.
	always_comb begin
		sqw_sum = CRH_PROD_W'(rxrx_s2) + CRH_PROD_W'(ryry_s2);
		sqh_sum = CRH_PROD_W'(txtx_s2) + CRH_PROD_W'(tyty_s2);
		crw_raw = (CRH_PROD_W+1)'(txcy_s2) - (CRH_PROD_W+1)'(tycx_s2);
		crh_raw = (CRH_PROD_W+1)'(rxcy_s2) - (CRH_PROD_W+1)'(rycx_s2);
		crw_abs = crw_raw[CRH_PROD_W] ? (CRH_PROD_W+1)'(-crw_raw) : (CRH_PROD_W+1)'(crw_raw);
		crh_abs = crh_raw[CRH_PROD_W] ? (CRH_PROD_W+1)'(-crh_raw) : (CRH_PROD_W+1)'(crh_raw);
	end

	// Stage 3: register the operands of the root and divide units.
	always_ff @(posedge clk) begin
		if (en) begin
			front_s3.sq_w <= sqw_sum[CRH_SUMSQ_W-1:0];
			front_s3.sq_h <= sqh_sum[CRH_SUMSQ_W-1:0];
			front_s3.cr_w <= crw_abs[CRH_NUM_W-1:0];
			front_s3.cr_h <= crh_abs[CRH_NUM_W-1:0];
			front_s3.r    <= r_s2;
		end
	end

	assign out_valid = v_s3;
	assign out_front = front_s3;

endmodule

### rtl/core/crh_sqrt2.sv
module crh_sqrt2 import crh_pkg::*; #(
	parameter int RT_W = CRH_RT_W,
	parameter int SB_W = $bits(sqrt_sb_t)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [2*RT_W-1:0] rad_a,
	input  logic [2*RT_W-1:0] rad_b,
	input  logic [SB_W-1:0]   in_sb,
	output logic              out_valid,
	output logic [RT_W-1:0]   root_a,
	output logic [RT_W-1:0]   root_b,
	output logic [SB_W-1:0]   out_sb
);

	localparam int RAD_W = 2 * RT_W;
	localparam int REM_W = RT_W + 2;
	localparam int CUR_W = RT_W + 3;

	// One result bit per stage, two independent lanes.
	logic [RT_W-1:0]  v_s;
	logic [REM_W-1:0] rem_s  [RT_W][2];
	logic [RT_W-1:0]  root_s [RT_W][2];
	logic [RAD_W-1:0] rad_s  [RT_W][2];
	logic [SB_W-1:0]  sb_s   [RT_W];

	logic [REM_W-1:0] rem_src  [RT_W][2];
	logic [RT_W-1:0]  root_src [RT_W][2];
	logic [RAD_W-1:0] rad_src  [RT_W][2];
	logic [REM_W-1:0] rem_nx   [RT_W][2];
	logic [RT_W-1:0]  root_nx  [RT_W][2];
	logic [RAD_W-1:0] rad_nx   [RT_W][2];

	// Digit-by-digit root: bring down two radicand bits, try (root << 2) | 1.
	always_comb begin
		logic [CUR_W-1:0] cur;
		logic [CUR_W-1:0] trial;
		rem_src[0][0]  = '0;
		rem_src[0][1]  = '0;
		root_src[0][0] = '0;
		root_src[0][1] = '0;
		rad_src[0][0]  = rad_a;
		rad_src[0][1]  = rad_b;
		for (int k = 1; k < RT_W; k++) begin
			for (int l = 0; l < 2; l++) begin
				rem_src[k][l]  = rem_s[k-1][l];
				root_src[k][l] = root_s[k-1][l];
				rad_src[k][l]  = rad_s[k-1][l];
			end
		end
		for (int k = 0; k < RT_W; k++) begin
			for (int l = 0; l < 2; l++) begin
				cur   = {rem_src[k][l][RT_W:0], rad_src[k][l][RAD_W-1 -: 2]};
				trial = {1'b0, root_src[k][l], 2'b01};
				if (cur >= trial) begin
					rem_nx[k][l]  = REM_W'(cur - trial);
					root_nx[k][l] = {root_src[k][l][RT_W-2:0], 1'b1};
				end else begin
					rem_nx[k][l]  = REM_W'(cur);
					root_nx[k][l] = {root_src[k][l][RT_W-2:0], 1'b0};
				end
				rad_nx[k][l] = {rad_src[k][l][RAD_W-3:0], 2'b00};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[RT_W-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < RT_W; k++) begin
				for (int l = 0; l < 2; l++) begin
					rem_s[k][l]  <= rem_nx[k][l];
					root_s[k][l] <= root_nx[k][l];
					rad_s[k][l]  <= rad_nx[k][l];
				end
			end
			sb_s[0] <= in_sb;
			for (int k = 1; k < RT_W; k++) begin
				sb_s[k] <= sb_s[k-1];
			end
		end
	end

	assign out_valid = v_s[RT_W-1];
	assign root_a    = root_s[RT_W-1][0];
	assign root_b    = root_s[RT_W-1][1];
	assign out_sb    = sb_s[RT_W-1];

endmodule

### rtl/core/crh_div2.sv
module crh_div2 import crh_pkg::*; #(
	parameter int N_W  = CRH_NUM_W,
	parameter int D_W  = CRH_RT_W,
	parameter int SB_W = CRH_R_W
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [N_W-1:0]  num_a,
	input  logic [D_W-1:0]  den_a,
	input  logic [N_W-1:0]  num_b,
	input  logic [D_W-1:0]  den_b,
	input  logic [SB_W-1:0] in_sb,
	output logic            out_valid,
	output logic [N_W-1:0]  quot_a,
	output logic [N_W-1:0]  quot_b,
	output logic [D_W-1:0]  out_den_a,
	output logic [D_W-1:0]  out_den_b,
	output logic [SB_W-1:0] out_sb
);

	// One quotient bit per stage. The numerator register shifts left and
	// takes the quotient bits in at the bottom.
	logic [N_W-1:0]  v_s;
	logic [D_W-1:0]  rem_s [N_W][2];
	logic [N_W-1:0]  q_s   [N_W][2];
	logic [D_W-1:0]  den_s [N_W][2];
	logic [SB_W-1:0] sb_s  [N_W];

	logic [D_W-1:0] rem_src [N_W][2];
	logic [N_W-1:0] q_src   [N_W][2];
	logic [D_W-1:0] den_src [N_W][2];
	logic [D_W-1:0] rem_nx  [N_W][2];
	logic [N_W-1:0] q_nx    [N_W][2];

	// Restoring division step.
	always_comb begin
		logic [D_W:0] cur;
		rem_src[0][0] = '0;
		rem_src[0][1] = '0;
		q_src[0][0]   = num_a;
		q_src[0][1]   = num_b;
		den_src[0][0] = den_a;
		den_src[0][1] = den_b;
		for (int k = 1; k < N_W; k++) begin
			for (int l = 0; l < 2; l++) begin
				rem_src[k][l] = rem_s[k-1][l];
				q_src[k][l]   = q_s[k-1][l];
				den_src[k][l] = den_s[k-1][l];
			end
		end
		for (int k = 0; k < N_W; k++) begin
			for (int l = 0; l < 2; l++) begin
				cur = {rem_src[k][l], q_src[k][l][N_W-1]};
				if (cur >= {1'b0, den_src[k][l]}) begin
					rem_nx[k][l] = D_W'(cur - {1'b0, den_src[k][l]});
					q_nx[k][l]   = {q_src[k][l][N_W-2:0], 1'b1};
				end else begin
					rem_nx[k][l] = cur[D_W-1:0];
					q_nx[k][l]   = {q_src[k][l][N_W-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[N_W-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < N_W; k++) begin
				for (int l = 0; l < 2; l++) begin
					rem_s[k][l] <= rem_nx[k][l];
					q_s[k][l]   <= q_nx[k][l];
					den_s[k][l] <= den_src[k][l];
				end
			end
			sb_s[0] <= in_sb;
			for (int k = 1; k < N_W; k++) begin
				sb_s[k] <= sb_s[k-1];
			end
		end
	end

	assign out_valid = v_s[N_W-1];
	assign quot_a    = q_s[N_W-1][0];
	assign quot_b    = q_s[N_W-1][1];
	assign out_den_a = den_s[N_W-1][0];
	assign out_den_b = den_s[N_W-1][1];
	assign out_sb    = sb_s[N_W-1];

endmodule

### rtl/core/crh_decide.sv
module crh_decide import crh_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [CRH_RT_W-1:0]  w1,
	input  logic [CRH_RT_W-1:0]  h1,
	input  logic [CRH_NUM_W-1:0] w2,
	input  logic [CRH_NUM_W-1:0] h2,
	input  logic [CRH_R_W-1:0]   r,
	output logic                 out_valid,
	output out_item_t            out_item
);

	localparam int CMP_W = CRH_NUM_W + 1;
	localparam int SQ_W  = 2 * CRH_DW_W;

	logic v_s1, v_s2, v_s3;
	logic deg_s1, rej_s1, ins_s1, deg_s2, rej_s2, ins_s2;
	logic [CRH_DW_W-1:0] dw_s1, dh_s1;
	logic [CRH_R_W-1:0]  r_s1;
	logic [SQ_W-1:0]     pw_s2, ph_s2;
	logic [2*CRH_R_W-1:0] pr_s2;
	out_item_t item_s3;

	logic [CMP_W-1:0] w1r, h1r;
	logic [SQ_W:0]    dist_sq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Reject bounds: half extent plus radius.
	always_comb begin
		w1r = CMP_W'(w1) + CMP_W'(r);
		h1r = CMP_W'(h1) + CMP_W'(r);
	end

	// Stage 1: early reject, inside band and corner offsets. The offsets are
	// only used when neither of the first two tests decides the item.
	always_ff @(posedge clk) begin
		if (en) begin
			deg_s1 <= (w1 == '0) || (h1 == '0);
			rej_s1 <= (CMP_W'(w2) > w1r) || (CMP_W'(h2) > h1r);
			ins_s1 <= (w2 <= CRH_NUM_W'(w1)) || (h2 <= CRH_NUM_W'(h1));
			dw_s1  <= CRH_DW_W'(w2 - CRH_NUM_W'(w1));
			dh_s1  <= CRH_DW_W'(h2 - CRH_NUM_W'(h1));
			r_s1   <= r;
		end
	end

	// Stage 2: squares for the corner distance test.
	always_ff @(posedge clk) begin
		if (en) begin
			pw_s2  <= SQ_W'(dw_s1) * SQ_W'(dw_s1);
			ph_s2  <= SQ_W'(dh_s1) * SQ_W'(dh_s1);
			pr_s2  <= (2*CRH_R_W)'(r_s1) * (2*CRH_R_W)'(r_s1);
			deg_s2 <= deg_s1;
			rej_s2 <= rej_s1;
			ins_s2 <= ins_s1;
		end
	end

	assign dist_sq = (SQ_W+1)'(pw_s2) + (SQ_W+1)'(ph_s2);

	// Stage 3: final decision, held in the output register.
	always_ff @(posedge clk) begin
		if (en) begin
			item_s3.degenerate <= deg_s2;
			item_s3.hit        <= !deg_s2 && !rej_s2 &&
				(ins_s2 || (dist_sq <= (SQ_W+1)'(pr_s2)));
		end
	end

	assign out_valid = v_s3;
	assign out_item  = item_s3;

endmodule

### rtl/core/circle_oriented_rect_hit.sv
// Circle against oriented rectangle hit test.
// Input channel in_valid / in_ready / in_item: one query per item, holding
// the circle centre and radius and the rectangle centre, top edge midpoint
// and right edge midpoint, all fixed point.
// Output channel out_valid / out_ready / out_item: one result per query, in
// query order, with hit and degenerate (an axis of zero length, never a hit).
// The pipeline holds 3 front end stages (offsets, products, sums), 25
// square root stages (one root bit each), 49 division stages (one
// quotient bit each) and 3 decision stages, in that order.
// Throughput is one item per cycle except while the output stalls.
// The whole pipeline advances together whenever the output register is
// empty or being read, so in_ready is low only while a result waits at the
// output and out_ready is low. Nothing is lost or repeated during a stall.
// Reset clears all valid bits; no result is pending after reset.
module circle_oriented_rect_hit import crh_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	logic en;

	logic   fr_valid;
	front_t fr_data;

	logic sq_valid;
	logic [CRH_RT_W-1:0] w1_sq, h1_sq;
	sqrt_sb_t sq_sb_in, sq_sb_out;

	logic dv_valid;
	logic [CRH_NUM_W-1:0] w2_dv, h2_dv;
	logic [CRH_RT_W-1:0]  h1_dv, w1_dv;
	logic [CRH_R_W-1:0]   r_dv;

	// Global advance: the output register is free or is being emptied.
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	crh_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.in_item   (in_item),
		.out_valid (fr_valid),
		.out_front (fr_data)
	);

	always_comb begin
		sq_sb_in.cr_w = fr_data.cr_w;
		sq_sb_in.cr_h = fr_data.cr_h;
		sq_sb_in.r    = fr_data.r;
	end

	// Half width from the right axis, half height from the top axis.
	crh_sqrt2 #(
		.RT_W (CRH_RT_W),
		.SB_W ($bits(sqrt_sb_t))
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (fr_valid),
		.rad_a     (CRH_RAD_W'(fr_data.sq_w)),
		.rad_b     (CRH_RAD_W'(fr_data.sq_h)),
		.in_sb     (sq_sb_in),
		.out_valid (sq_valid),
		.root_a    (w1_sq),
		.root_b    (h1_sq),
		.out_sb    (sq_sb_out)
	);

	// Distances to the axes: cross magnitude over axis length.
	crh_div2 #(
		.N_W  (CRH_NUM_W),
		.D_W  (CRH_RT_W),
		.SB_W (CRH_R_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid),
		.num_a     (sq_sb_out.cr_w),
		.den_a     (h1_sq),
		.num_b     (sq_sb_out.cr_h),
		.den_b     (w1_sq),
		.in_sb     (sq_sb_out.r),
		.out_valid (dv_valid),
		.quot_a    (w2_dv),
		.quot_b    (h2_dv),
		.out_den_a (h1_dv),
		.out_den_b (w1_dv),
		.out_sb    (r_dv)
	);

	crh_decide u_decide (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (dv_valid),
		.w1        (w1_dv),
		.h1        (h1_dv),
		.w2        (w2_dv),
		.h2        (h2_dv),
		.r         (r_dv),
		.out_valid (out_valid),
		.out_item  (out_item)
	);

`include "assert_macros.svh"

	// A degenerate rectangle never reports a hit.
	`CRH_ASSERT_IMPLY(a_deg_no_hit, out_valid && out_item.degenerate, !out_item.hit)
	// The input side only stalls while a finished result is waiting.
	`CRH_ASSERT_IMPLY(a_stall_cause, !in_ready, out_valid && !out_ready)
	// A waiting result is still there in the next cycle.
	`CRH_ASSERT_NEXT(a_result_kept, out_valid && !out_ready, out_valid)

endmodule
